// File: rtl/core/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants of the track duplicate filter: field widths,
// the stored track record, the window register set and the sequencer codes.
// ----------------------------------------------------------------------------
package tdf_pkg;

  // Candidate field widths (two's complement)
  localparam int CURV_W = 20;
  localparam int PHI_W  = 18;
  localparam int ETA_W  = 15;
  localparam int Z_W    = 16;

  // Window register widths (unsigned)
  localparam int CURV_WIN_W = 19;
  localparam int PHI_WIN_W  = 17;
  localparam int ETA_WIN_W  = 14;
  localparam int Z_WIN_W    = 15;

  // Configuration port and result widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int MATCH_W    = 6;

  // Window reset values
  localparam logic [CURV_WIN_W-1:0] CURV_WIN_RST = CURV_WIN_W'(102);
  localparam logic [PHI_WIN_W-1:0]  PHI_WIN_RST  = PHI_WIN_W'(82);
  localparam logic [ETA_WIN_W-1:0]  ETA_WIN_RST  = ETA_WIN_W'(82);
  localparam logic [Z_WIN_W-1:0]    Z_WIN_RST    = Z_WIN_W'(307);

  // One kept track as stored in the table
  typedef struct packed {
    logic signed [CURV_W-1:0] curvature;
    logic signed [PHI_W-1:0]  phi_angle;
    logic signed [ETA_W-1:0]  pseudorapidity;
    logic signed [Z_W-1:0]    z_origin;
  } track_t;

  // Duplicate windows
  typedef struct packed {
    logic [CURV_WIN_W-1:0] curvature;
    logic [PHI_WIN_W-1:0]  phi_angle;
    logic [ETA_WIN_W-1:0]  pseudorapidity;
    logic [Z_WIN_W-1:0]    z_origin;
  } windows_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURV_WIN = 2'd0,
    CFG_PHI_WIN  = 2'd1,
    CFG_ETA_WIN  = 2'd2,
    CFG_Z_WIN    = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } tdf_state_t;

endpackage

// File: rtl/core/tdf_cfg_if.sv
// ----------------------------------------------------------------------------
// tdf_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface tdf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tdf_pkg::CFG_IDX_W-1:0]   index;
  logic [tdf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/tdf_in_if.sv
// ----------------------------------------------------------------------------
// tdf_in_if
// Candidate channel: one track candidate per beat.
// ----------------------------------------------------------------------------
interface tdf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                start_of_event;
  logic signed [tdf_pkg::CURV_W-1:0]   curvature;
  logic signed [tdf_pkg::PHI_W-1:0]    phi_angle;
  logic signed [tdf_pkg::ETA_W-1:0]    pseudorapidity;
  logic signed [tdf_pkg::Z_W-1:0]      z_origin;

  modport source (output valid, output start_of_event, output curvature,
                  output phi_angle, output pseudorapidity, output z_origin,
                  input ready);
  modport sink   (input valid, input start_of_event, input curvature,
                  input phi_angle, input pseudorapidity, input z_origin,
                  output ready);
endinterface

// File: rtl/core/tdf_out_if.sv
// ----------------------------------------------------------------------------
// tdf_out_if
// Result channel: one verdict per candidate beat.
// ----------------------------------------------------------------------------
interface tdf_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kept;
  logic [tdf_pkg::MATCH_W-1:0]    match_index;
  logic                           table_overflow;

  modport source (output valid, output kept, output match_index,
                  output table_overflow, input ready);
  modport sink   (input valid, input kept, input match_index,
                  input table_overflow, output ready);
endinterface

// File: rtl/core/tdf_compare.sv
// ----------------------------------------------------------------------------
// tdf_compare
// Duplicate test of a candidate against one stored track: all four absolute
// differences, formed at full width, must lie strictly below their windows.
// ----------------------------------------------------------------------------
module tdf_compare (
  input  tdf_pkg::track_t   cand,
  input  tdf_pkg::track_t   stored,
  input  tdf_pkg::windows_t win,
  output logic              match
);
  import tdf_pkg::*;

  logic signed [CURV_W:0] curv_diff;
  logic signed [PHI_W:0]  phi_diff;
  logic signed [ETA_W:0]  eta_diff;
  logic signed [Z_W:0]    z_diff;
  logic        [CURV_W:0] curv_abs;
  logic        [PHI_W:0]  phi_abs;
  logic        [ETA_W:0]  eta_abs;
  logic        [Z_W:0]    z_abs;
  logic                   curv_ok;
  logic                   phi_ok;
  logic                   eta_ok;
  logic                   z_ok;

  // Differences one bit wider than the fields, so they never wrap
  assign curv_diff = {cand.curvature[CURV_W-1], cand.curvature}
                   - {stored.curvature[CURV_W-1], stored.curvature};
  assign phi_diff  = {cand.phi_angle[PHI_W-1], cand.phi_angle}
                   - {stored.phi_angle[PHI_W-1], stored.phi_angle};
  assign eta_diff  = {cand.pseudorapidity[ETA_W-1], cand.pseudorapidity}
                   - {stored.pseudorapidity[ETA_W-1], stored.pseudorapidity};
  assign z_diff    = {cand.z_origin[Z_W-1], cand.z_origin}
                   - {stored.z_origin[Z_W-1], stored.z_origin};

  // Magnitudes read as unsigned, so the most negative difference stays exact
  assign curv_abs = curv_diff[CURV_W] ? -curv_diff : curv_diff;
  assign phi_abs  = phi_diff[PHI_W]   ? -phi_diff  : phi_diff;
  assign eta_abs  = eta_diff[ETA_W]   ? -eta_diff  : eta_diff;
  assign z_abs    = z_diff[Z_W]       ? -z_diff    : z_diff;

  // Strict compare against the windows
  assign curv_ok = curv_abs < (CURV_W+1)'(win.curvature);
  assign phi_ok  = phi_abs  < (PHI_W+1)'(win.phi_angle);
  assign eta_ok  = eta_abs  < (ETA_W+1)'(win.pseudorapidity);
  assign z_ok    = z_abs    < (Z_W+1)'(win.z_origin);

  assign match = curv_ok && phi_ok && eta_ok && z_ok;

endmodule

// File: rtl/core/track_duplicate_filter_unit.sv
// ----------------------------------------------------------------------------
// track_duplicate_filter_unit
// Drops track candidates that repeat a track already kept in the event.
//
// Channels: in_ch takes one candidate per beat; start_of_event on a beat
// empties the kept-track table before that candidate is tested. out_ch gives
// one verdict per candidate: kept, the first matching slot for a duplicate,
// and table_overflow when a unique track found the table full. cfg_ch writes
// the four duplicate windows (index 0 curvature, 1 phi, 2 eta, 3 z0), always
// ready; the user writes it only while no candidate is in flight (unchecked).
//
// Timing: the kept tracks sit in one single-port table read one slot per
// cycle while scanning. A candidate is tested from slot 0 up to its first
// match or the last kept slot, then passes a finish step; an empty table
// skips the scan. The worst case, a full table, scans all MAX_KEPT slots.
//
// Reset empties the table (the count goes to zero; no clearing pass) and
// loads the window reset values. The verdict sits in an output register, so
// a new candidate is accepted while it waits; a stalled receiver holds the
// block only when the next verdict is ready to be loaded.
// ----------------------------------------------------------------------------
module track_duplicate_filter_unit #(
  parameter int MAX_KEPT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  tdf_cfg_if.sink           cfg_ch,
  tdf_in_if.sink            in_ch,
  tdf_out_if.source         out_ch
);
  import tdf_pkg::*;

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_KEPT);

  // Table storage
  track_t             track_mem [MAX_KEPT];
  track_t             rd_data_r;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;

  // Sequencer
  tdf_state_t         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      scan_idx_r, scan_idx_nxt;
  logic               res_kept_r, res_kept_nxt;
  logic [AW-1:0]      res_idx_r, res_idx_nxt;
  track_t             cand_r;
  windows_t           windows_r;
  logic               in_ready;
  logic               in_fire;
  logic               hit;
  logic               scan_last;
  logic               table_full;
  logic               out_load;

  // Result register
  logic               out_valid_r;
  logic               out_kept_r;
  logic [MATCH_W-1:0] out_idx_r;
  logic               out_overflow_r;

  // Window registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      windows_r <= '{curvature: CURV_WIN_RST, phi_angle: PHI_WIN_RST,
                     pseudorapidity: ETA_WIN_RST, z_origin: Z_WIN_RST};
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_CURV_WIN: windows_r.curvature      <= cfg_ch.data[CURV_WIN_W-1:0];
        CFG_PHI_WIN:  windows_r.phi_angle      <= cfg_ch.data[PHI_WIN_W-1:0];
        CFG_ETA_WIN:  windows_r.pseudorapidity <= cfg_ch.data[ETA_WIN_W-1:0];
        CFG_Z_WIN:    windows_r.z_origin       <= cfg_ch.data[Z_WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the candidate for the whole scan
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ready && in_ch.valid;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cand_r <= '{curvature: in_ch.curvature, phi_angle: in_ch.phi_angle,
                  pseudorapidity: in_ch.pseudorapidity, z_origin: in_ch.z_origin};
    end
  end

  // Table: one write or one registered read per cycle. Writes happen only in
  // the finish step, reads only on accept and in a scan: they never overlap.
  assign mem_wr_addr = count_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      track_mem[mem_wr_addr] <= cand_r;
    end
    if (mem_rd_en) begin
      rd_data_r <= track_mem[mem_rd_addr];
    end
  end

  // Compare the candidate with the slot just read
  tdf_compare u_compare (
    .cand   (cand_r),
    .stored (rd_data_r),
    .win    (windows_r),
    .match  (hit)
  );

  assign scan_last  = (CW'(scan_idx_r) + CW'(1)) == count_r;
  assign table_full = count_r == COUNT_FULL;

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    res_kept_r <= res_kept_nxt;
    res_idx_r  <= res_idx_nxt;
  end

  // Next state, table access and result capture
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    res_kept_nxt = res_kept_r;
    res_idx_nxt  = res_idx_r;
    in_ready     = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = '0;
    mem_wr_en    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          scan_idx_nxt = '0;
          if (in_ch.start_of_event) begin
            count_nxt = '0;
          end
          if (in_ch.start_of_event || count_r == '0) begin
            // Empty table: unique without a scan
            res_kept_nxt = 1'b1;
            res_idx_nxt  = '0;
            state_nxt    = ST_FINISH;
          end else begin
            mem_rd_en = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        priority if (hit) begin
          res_kept_nxt = 1'b0;
          res_idx_nxt  = scan_idx_r;
          state_nxt    = ST_FINISH;
        end else if (scan_last) begin
          res_kept_nxt = 1'b1;
          res_idx_nxt  = '0;
          state_nxt    = ST_FINISH;
        end else begin
          // Advance to the next slot
          mem_rd_en    = 1'b1;
          mem_rd_addr  = scan_idx_r + AW'(1);
          scan_idx_nxt = scan_idx_r + AW'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (res_kept_r && !table_full) begin
            mem_wr_en = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kept_r     <= res_kept_r;
      out_idx_r      <= MATCH_W'(res_idx_r);
      out_overflow_r <= res_kept_r && table_full;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kept           = out_kept_r;
  assign out_ch.match_index    = out_idx_r;
  assign out_ch.table_overflow = out_overflow_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("candidate accepted but sequencer stayed idle");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("kept-track count beyond table depth");

  a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_kept_r && !table_full |=> count_r == $past(count_r) + CW'(1))
    else $error("stored track not counted");

  a_dup_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_kept_r |-> !out_overflow_r)
    else $error("duplicate verdict flagged overflow");
`endif

endmodule
